// ----- sv/rpsf_pkg.sv -----
`timescale 1ns / 1ps

package rpsf_pkg;

	// Field widths
	localparam int unsigned ADDR_W  = 40;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned TMO_W   = 16;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned CMD_W   = 8;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W = 3;

	// Packet command codes and lengths
	localparam logic [CMD_W-1:0] CMD_REQUEST_CODE  = 8'd1;
	localparam logic [CMD_W-1:0] CMD_RESPONSE_CODE = 8'd2;
	localparam logic [CMD_W-1:0] CMD_PING_CODE     = 8'd3;
	localparam logic [CMD_W-1:0] CMD_PONG_CODE     = 8'd4;
	localparam logic [LEN_W-1:0] RESPONSE_LENGTH   = 6'd6;
	localparam logic [LEN_W-1:0] VERIFY_LENGTH     = 6'd8;

	// Kinds of packet sent
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_PONG    = 1'b1;

	// Register reset values
	localparam logic [ADDR_W-1:0]  DEFAULT_ADDRESS_RST = 40'd733295205870;
	localparam logic [WORD_W-1:0]  DEVICE_ID_RST       = 32'd272914040;
	localparam logic [WORD_W-1:0]  HOST_MAGIC_RST      = 32'd0;
	localparam logic [WORD_W-1:0]  SLAVE_MAGIC_RST     = 32'd0;
	localparam logic [COUNT_W-1:0] VERIFY_TARGET_RST   = 8'd5;
	localparam logic [TMO_W-1:0]   RESPONSE_TMO_RST    = 16'd100;
	localparam logic [TMO_W-1:0]   VERIFY_TMO_RST      = 16'd5000;
	localparam logic [TMO_W-1:0]   SILENT_DONE_RST     = 16'd3000;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Pairing phases, encoded as reported on the result channel
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE   = 3'd0,
		PH_SEND   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_VERIFY = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEFAULT_ADDRESS = 3'd0,
		REG_DEVICE_ID       = 3'd1,
		REG_HOST_MAGIC      = 3'd2,
		REG_SLAVE_MAGIC     = 3'd3,
		REG_VERIFY_TARGET   = 3'd4,
		REG_RESPONSE_TMO    = 3'd5,
		REG_VERIFY_TMO      = 3'd6,
		REG_SILENT_DONE     = 3'd7
	} cfg_reg_t;

endpackage

// ----- sv/rpsf_poll_if.sv -----
`timescale 1ns / 1ps

// One poll beat: enable level, time stamp and an optional received packet.
interface rpsf_poll_if;
	logic                              valid;
	logic                              ready;
	logic                              enable;
	logic [rpsf_pkg::TIME_W-1:0]       now_ms;
	logic                              rx_valid;
	logic [rpsf_pkg::LEN_W-1:0]        rx_length;
	logic [rpsf_pkg::CMD_W-1:0]        rx_command;
	logic [rpsf_pkg::WORD_W-1:0]       rx_magic;
	logic [rpsf_pkg::ADDR_W-1:0]       rx_granted_address;

	modport source (
		output valid, enable, now_ms, rx_valid, rx_length, rx_command, rx_magic,
		       rx_granted_address,
		input  ready
	);

	modport sink (
		input  valid, enable, now_ms, rx_valid, rx_length, rx_command, rx_magic,
		       rx_granted_address,
		output ready
	);
endinterface

// ----- sv/rpsf_result_if.sv -----
`timescale 1ns / 1ps

// One result beat per poll.
interface rpsf_result_if;
	logic                              valid;
	logic                              ready;
	logic                              send_valid;
	logic                              send_kind;
	logic [rpsf_pkg::WORD_W-1:0]       send_word;
	logic [rpsf_pkg::ADDR_W-1:0]       send_address;
	logic [rpsf_pkg::ADDR_W-1:0]       link_address;
	logic                              rx_flush;
	logic [rpsf_pkg::PHASE_W-1:0]      phase;
	logic [rpsf_pkg::COUNT_W-1:0]      verify_count;
	logic                              finish;

	modport source (
		output valid, send_valid, send_kind, send_word, send_address, link_address,
		       rx_flush, phase, verify_count, finish,
		input  ready
	);

	modport sink (
		input  valid, send_valid, send_kind, send_word, send_address, link_address,
		       rx_flush, phase, verify_count, finish,
		output ready
	);
endinterface

// ----- sv/radio_pairing_slave_fsm_top.sv -----
`timescale 1ns / 1ps

// Slave side of a radio pairing exchange, advanced by one poll per beat.
// The poll channel carries the enable level, the millisecond time and an
// optional received packet; the result channel returns exactly one beat per
// poll: the packet to send (request or pong), the link address, the receive
// flush strobe, the phase, the ping count and the finish flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) that the
// user must use only while no poll is in flight; the block does not enforce it.
// A poll is captured in an input register and evaluated against the pairing
// state once the result register is free or being emptied; the outcome is
// registered in the result register, which offers its beat. One poll is
// accepted every cycle while the receiver keeps up; the state update is a few
// 32-bit subtracts and compares, all combinational between the two registers.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more poll; poll.ready drops only when both are full.
// Reset (arst_n low) clears the pairing state to idle, restores all
// configuration registers to their defaults and sets the link address to
// the default pairing address. No clearing pass is needed.
module radio_pairing_slave_fsm_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rpsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rpsf_pkg::ADDR_W-1:0]          cfg_data,
	rpsf_poll_if.sink                            poll,
	rpsf_result_if.source                        result
);

	// Configuration registers
	logic [rpsf_pkg::ADDR_W-1:0]  default_address_q;
	logic [rpsf_pkg::WORD_W-1:0]  device_id_q;
	logic [rpsf_pkg::WORD_W-1:0]  host_magic_q;
	logic [rpsf_pkg::WORD_W-1:0]  slave_magic_q;
	logic [rpsf_pkg::COUNT_W-1:0] verify_target_q;
	logic [rpsf_pkg::TMO_W-1:0]   response_tmo_q;
	logic [rpsf_pkg::TMO_W-1:0]   verify_tmo_q;
	logic [rpsf_pkg::TMO_W-1:0]   silent_done_q;

	// Pairing state
	rpsf_pkg::phase_t             phase_q;
	logic                         enable_prev_q;
	logic [rpsf_pkg::TIME_W-1:0]  wait_start_q;
	logic [rpsf_pkg::TIME_W-1:0]  last_ping_q;
	logic [rpsf_pkg::COUNT_W-1:0] ping_count_q;
	logic                         goal_q;
	logic [rpsf_pkg::ADDR_W-1:0]  granted_q;
	logic [rpsf_pkg::ADDR_W-1:0]  current_q;

	// Input stage
	logic                         valid_s1;
	logic                         enable_s1;
	logic [rpsf_pkg::TIME_W-1:0]  now_s1;
	logic                         rx_valid_s1;
	logic [rpsf_pkg::LEN_W-1:0]   rx_length_s1;
	logic [rpsf_pkg::CMD_W-1:0]   rx_command_s1;
	logic [rpsf_pkg::WORD_W-1:0]  rx_magic_s1;
	logic [rpsf_pkg::ADDR_W-1:0]  rx_addr_s1;

	// Result stage
	logic                         valid_s2;
	logic                         send_valid_s2;
	logic                         send_kind_s2;
	logic [rpsf_pkg::WORD_W-1:0]  send_word_s2;
	logic [rpsf_pkg::ADDR_W-1:0]  send_address_s2;
	logic [rpsf_pkg::ADDR_W-1:0]  link_address_s2;
	logic                         rx_flush_s2;
	logic [rpsf_pkg::PHASE_W-1:0] phase_s2;
	logic [rpsf_pkg::COUNT_W-1:0] count_s2;
	logic                         finish_s2;

	// Evaluation signals
	logic                         fire;
	logic                         rise;
	rpsf_pkg::phase_t             phase_e;
	rpsf_pkg::phase_t             phase_d;
	logic [rpsf_pkg::TIME_W-1:0]  wait_e;
	logic [rpsf_pkg::TIME_W-1:0]  last_e;
	logic [rpsf_pkg::COUNT_W-1:0] count_e;
	logic                         goal_e;
	logic [rpsf_pkg::ADDR_W-1:0]  granted_e;
	logic [rpsf_pkg::ADDR_W-1:0]  current_e;
	logic [rpsf_pkg::TIME_W-1:0]  wait_d;
	logic [rpsf_pkg::TIME_W-1:0]  last_d;
	logic [rpsf_pkg::COUNT_W-1:0] count_d;
	logic                         goal_d;
	logic [rpsf_pkg::ADDR_W-1:0]  granted_d;
	logic [rpsf_pkg::ADDR_W-1:0]  current_d;
	logic [rpsf_pkg::COUNT_W-1:0] count_inc;
	logic [rpsf_pkg::TIME_W-1:0]  since_wait;
	logic [rpsf_pkg::TIME_W-1:0]  since_ping;
	logic                         resp_ok;
	logic                         ping_ok;
	logic                         resp_tmo;
	logic                         verify_tmo;
	logic                         silent_tmo;
	logic                         send_valid_d;
	logic                         send_kind_d;
	logic [rpsf_pkg::WORD_W-1:0]  send_word_d;
	logic [rpsf_pkg::ADDR_W-1:0]  send_address_d;
	logic                         rx_flush_d;
	logic                         finish_d;

	// Handshake: evaluate when the result register is free or being emptied.
	assign fire       = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || fire;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_address_q <= rpsf_pkg::DEFAULT_ADDRESS_RST;
			device_id_q       <= rpsf_pkg::DEVICE_ID_RST;
			host_magic_q      <= rpsf_pkg::HOST_MAGIC_RST;
			slave_magic_q     <= rpsf_pkg::SLAVE_MAGIC_RST;
			verify_target_q   <= rpsf_pkg::VERIFY_TARGET_RST;
			response_tmo_q    <= rpsf_pkg::RESPONSE_TMO_RST;
			verify_tmo_q      <= rpsf_pkg::VERIFY_TMO_RST;
			silent_done_q     <= rpsf_pkg::SILENT_DONE_RST;
		end else if (cfg_we) begin
			unique case (rpsf_pkg::cfg_reg_t'(cfg_index))
				rpsf_pkg::REG_DEFAULT_ADDRESS: default_address_q <= cfg_data;
				rpsf_pkg::REG_DEVICE_ID:     device_id_q   <= cfg_data[rpsf_pkg::WORD_W-1:0];
				rpsf_pkg::REG_HOST_MAGIC:    host_magic_q  <= cfg_data[rpsf_pkg::WORD_W-1:0];
				rpsf_pkg::REG_SLAVE_MAGIC:   slave_magic_q <= cfg_data[rpsf_pkg::WORD_W-1:0];
				rpsf_pkg::REG_VERIFY_TARGET:
					verify_target_q <= cfg_data[rpsf_pkg::COUNT_W-1:0];
				rpsf_pkg::REG_RESPONSE_TMO:  response_tmo_q <= cfg_data[rpsf_pkg::TMO_W-1:0];
				rpsf_pkg::REG_VERIFY_TMO:    verify_tmo_q   <= cfg_data[rpsf_pkg::TMO_W-1:0];
				rpsf_pkg::REG_SILENT_DONE:   silent_done_q  <= cfg_data[rpsf_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			enable_s1     <= poll.enable;
			now_s1        <= poll.now_ms;
			rx_valid_s1   <= poll.rx_valid;
			rx_length_s1  <= poll.rx_length;
			rx_command_s1 <= poll.rx_command;
			rx_magic_s1   <= poll.rx_magic;
			rx_addr_s1    <= poll.rx_granted_address;
		end
	end

	// A rising edge of enable clears the session before the phase is run.
	assign rise      = enable_s1 && !enable_prev_q;
	assign phase_e   = rise ? rpsf_pkg::PH_IDLE : phase_q;
	assign wait_e    = rise ? '0 : wait_start_q;
	assign last_e    = rise ? '0 : last_ping_q;
	assign count_e   = rise ? '0 : ping_count_q;
	assign goal_e    = rise ? 1'b0 : goal_q;
	assign granted_e = rise ? '0 : granted_q;
	assign current_e = rise ? default_address_q : current_q;

	// Packet checks and wrapping time compares
	assign resp_ok = rx_valid_s1 && (rx_length_s1 == rpsf_pkg::RESPONSE_LENGTH)
		&& (rx_command_s1 == rpsf_pkg::CMD_RESPONSE_CODE);
	assign ping_ok = rx_valid_s1 && (rx_length_s1 == rpsf_pkg::VERIFY_LENGTH)
		&& (rx_command_s1 == rpsf_pkg::CMD_PING_CODE) && (rx_magic_s1 == host_magic_q);
	assign since_wait = now_s1 - wait_e;
	assign since_ping = now_s1 - last_e;
	assign resp_tmo   = since_wait > {{(rpsf_pkg::TIME_W-rpsf_pkg::TMO_W){1'b0}}, response_tmo_q};
	assign verify_tmo = since_wait > {{(rpsf_pkg::TIME_W-rpsf_pkg::TMO_W){1'b0}}, verify_tmo_q};
	assign silent_tmo = since_ping > {{(rpsf_pkg::TIME_W-rpsf_pkg::TMO_W){1'b0}}, silent_done_q};
	assign count_inc  = (count_e != rpsf_pkg::COUNT_MAX) ? count_e + 1'b1 : count_e;

	// Next phase. A valid ping restarts both timers, so it never times out.
	always_comb begin
		phase_d = phase_e;
		if (!enable_s1) begin
			phase_d = rpsf_pkg::PH_IDLE;
		end else begin
			unique case (phase_e)
				rpsf_pkg::PH_IDLE: phase_d = rpsf_pkg::PH_SEND;
				rpsf_pkg::PH_SEND: phase_d = rpsf_pkg::PH_WAIT;
				rpsf_pkg::PH_WAIT: begin
					if (resp_ok)
						phase_d = rpsf_pkg::PH_VERIFY;
					else if (resp_tmo)
						phase_d = rpsf_pkg::PH_SEND;
				end
				rpsf_pkg::PH_VERIFY: begin
					if (!ping_ok) begin
						if (goal_e) begin
							if (silent_tmo)
								phase_d = rpsf_pkg::PH_DONE;
						end else if (verify_tmo) begin
							phase_d = rpsf_pkg::PH_SEND;
						end
					end
				end
				rpsf_pkg::PH_DONE: phase_d = rpsf_pkg::PH_DONE;
				default: phase_d = rpsf_pkg::PH_IDLE;
			endcase
		end
	end

	// Session registers and result fields for this poll
	always_comb begin
		wait_d         = wait_e;
		last_d         = last_e;
		count_d        = count_e;
		goal_d         = goal_e;
		granted_d      = granted_e;
		current_d      = current_e;
		send_valid_d   = 1'b0;
		send_kind_d    = rpsf_pkg::KIND_REQUEST;
		send_word_d    = '0;
		send_address_d = '0;
		rx_flush_d     = 1'b0;
		finish_d       = 1'b0;
		if (enable_s1) begin
			unique case (phase_e)
				rpsf_pkg::PH_SEND: begin
					current_d      = default_address_q;
					send_valid_d   = 1'b1;
					send_word_d    = device_id_q;
					send_address_d = default_address_q;
					wait_d         = now_s1;
				end
				rpsf_pkg::PH_WAIT: begin
					if (resp_ok) begin
						granted_d  = rx_addr_s1;
						current_d  = rx_addr_s1;
						rx_flush_d = 1'b1;
						count_d    = '0;
						wait_d     = now_s1;
					end
				end
				rpsf_pkg::PH_VERIFY: begin
					if (ping_ok) begin
						wait_d         = now_s1;
						last_d         = now_s1;
						send_valid_d   = 1'b1;
						send_kind_d    = rpsf_pkg::KIND_PONG;
						send_word_d    = slave_magic_q;
						send_address_d = granted_e;
						count_d        = count_inc;
						goal_d         = goal_e || (count_inc >= verify_target_q);
					end
				end
				rpsf_pkg::PH_DONE: finish_d = 1'b1;
				default: ;
			endcase
		end
	end

	// Pairing state update, once per evaluated poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= rpsf_pkg::PH_IDLE;
			enable_prev_q <= 1'b0;
			wait_start_q  <= '0;
			last_ping_q   <= '0;
			ping_count_q  <= '0;
			goal_q        <= 1'b0;
			granted_q     <= '0;
			current_q     <= rpsf_pkg::DEFAULT_ADDRESS_RST;
		end else if (fire) begin
			phase_q       <= phase_d;
			enable_prev_q <= enable_s1;
			wait_start_q  <= wait_d;
			last_ping_q   <= last_d;
			ping_count_q  <= count_d;
			goal_q        <= goal_d;
			granted_q     <= granted_d;
			current_q     <= current_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			send_valid_s2   <= send_valid_d;
			send_kind_s2    <= send_kind_d;
			send_word_s2    <= send_word_d;
			send_address_s2 <= send_address_d;
			link_address_s2 <= current_d;
			rx_flush_s2     <= rx_flush_d;
			phase_s2        <= phase_d;
			count_s2        <= count_d;
			finish_s2       <= finish_d;
		end
	end

	assign result.valid        = valid_s2;
	assign result.send_valid   = send_valid_s2;
	assign result.send_kind    = send_kind_s2;
	assign result.send_word    = send_word_s2;
	assign result.send_address = send_address_s2;
	assign result.link_address = link_address_s2;
	assign result.rx_flush     = rx_flush_s2;
	assign result.phase        = phase_s2;
	assign result.verify_count = count_s2;
	assign result.finish       = finish_s2;

	// Finish is only reported from the done phase.
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.finish |-> result.phase == rpsf_pkg::PH_DONE)
		else $error("finish outside done phase");

	// An address switch enters verify with a fresh count.
	a_flush_verify: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.rx_flush |->
		result.phase == rpsf_pkg::PH_VERIFY && result.verify_count == '0)
		else $error("receive flush without entry to verify");

	// A pong goes to the granted address, which is the link address in verify.
	a_pong_link: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.send_valid && result.send_kind == rpsf_pkg::KIND_PONG |->
		result.phase == rpsf_pkg::PH_VERIFY && result.send_address == result.link_address)
		else $error("pong outside verify or off the link address");

	// A request goes out on the link address and leads to the wait phase.
	a_request_wait: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.send_valid && result.send_kind == rpsf_pkg::KIND_REQUEST |->
		result.phase == rpsf_pkg::PH_WAIT && result.send_address == result.link_address)
		else $error("request not followed by wait phase");

endmodule

// ----- test/rpsf_checker.sv -----
`timescale 1ns / 1ps

// Watches the poll and result channels and the configuration write port.
// Every accepted poll is run through a local copy of the pairing state, and
// the outcome is queued; every accepted result beat is compared field by
// field against the oldest queued outcome.
module rpsf_checker
	import rpsf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [ADDR_W-1:0]     cfg_data,
	rpsf_poll_if                  poll,
	rpsf_result_if                result,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	typedef struct packed {
		logic               send_valid;
		logic               send_kind;
		logic [WORD_W-1:0]  send_word;
		logic [ADDR_W-1:0]  send_address;
		logic [ADDR_W-1:0]  link_address;
		logic               rx_flush;
		logic [PHASE_W-1:0] phase;
		logic [COUNT_W-1:0] verify_count;
		logic               finish;
	} pairing_outcome_t;

	// Register copies.
	logic [ADDR_W-1:0]  cfg_default_addr;
	logic [WORD_W-1:0]  cfg_device_id;
	logic [WORD_W-1:0]  cfg_host_magic;
	logic [WORD_W-1:0]  cfg_slave_magic;
	logic [COUNT_W-1:0] cfg_target;
	logic [TMO_W-1:0]   cfg_response_tmo;
	logic [TMO_W-1:0]   cfg_verify_tmo;
	logic [TMO_W-1:0]   cfg_silent_done;

	// Pairing state as the block should hold it.
	phase_t             ph;
	logic               en_seen;
	logic [TIME_W-1:0]  wait_from_ms;
	logic [TIME_W-1:0]  last_ping_at;
	logic [COUNT_W-1:0] pings;
	logic               goal_met;
	logic [ADDR_W-1:0]  granted_addr;
	logic [ADDR_W-1:0]  link_addr;

	pairing_outcome_t   pending_outcomes[$];
	int unsigned        fail_count;
	int unsigned        beats_seen;

	// Prints one line per mismatch and counts them all.
	task automatic report_mismatch(input string msg);
		$display("mismatch at result beat %0d: %s", beats_seen, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Advances the local pairing state by the poll now on the channel.
	task automatic predict_poll(output pairing_outcome_t o);
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] since_wait;
		logic [TIME_W-1:0] since_ping;
		logic              good_response;
		logic              good_ping;
		now = poll.now_ms;
		o = '0;
		good_response = poll.rx_valid && poll.rx_length == RESPONSE_LENGTH &&
			poll.rx_command == CMD_RESPONSE_CODE;
		good_ping = poll.rx_valid && poll.rx_length == VERIFY_LENGTH &&
			poll.rx_command == CMD_PING_CODE && poll.rx_magic == cfg_host_magic;

		if (!poll.enable) begin
			ph = PH_IDLE;
			en_seen = 1'b0;
		end else begin
			// A rising enable restarts the exchange from scratch.
			if (!en_seen) begin
				en_seen = 1'b1;
				ph = PH_IDLE;
				wait_from_ms = '0;
				last_ping_at = '0;
				pings = '0;
				goal_met = 1'b0;
				granted_addr = '0;
				link_addr = cfg_default_addr;
			end
			case (ph)
				PH_IDLE: begin
					ph = PH_SEND;
				end
				PH_SEND: begin
					link_addr = cfg_default_addr;
					o.send_valid = 1'b1;
					o.send_kind = KIND_REQUEST;
					o.send_word = cfg_device_id;
					o.send_address = cfg_default_addr;
					wait_from_ms = now;
					ph = PH_WAIT;
				end
				PH_WAIT: begin
					since_wait = now - wait_from_ms;
					if (good_response) begin
						granted_addr = poll.rx_granted_address;
						o.rx_flush = 1'b1;
						link_addr = poll.rx_granted_address;
						pings = '0;
						wait_from_ms = now;
						ph = PH_VERIFY;
					end else if (since_wait > TIME_W'(cfg_response_tmo)) begin
						ph = PH_SEND;
					end
				end
				PH_VERIFY: begin
					if (good_ping) begin
						wait_from_ms = now;
						last_ping_at = now;
						o.send_valid = 1'b1;
						o.send_kind = KIND_PONG;
						o.send_word = cfg_slave_magic;
						o.send_address = granted_addr;
						if (pings != COUNT_MAX)
							pings = pings + 1'b1;
						if (pings >= cfg_target)
							goal_met = 1'b1;
					end
					since_wait = now - wait_from_ms;
					since_ping = now - last_ping_at;
					// Once the goal is met only host silence matters.
					if (goal_met) begin
						if (since_ping > TIME_W'(cfg_silent_done))
							ph = PH_DONE;
					end else if (since_wait > TIME_W'(cfg_verify_tmo)) begin
						ph = PH_SEND;
					end
				end
				PH_DONE: begin
					o.finish = 1'b1;
				end
				default: begin
					ph = PH_IDLE;
				end
			endcase
		end
		o.link_address = link_addr;
		o.phase = ph;
		o.verify_count = pings;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pairing_outcome_t want;
		pairing_outcome_t fresh;
		if (!arst_n) begin
			cfg_default_addr <= DEFAULT_ADDRESS_RST;
			cfg_device_id <= DEVICE_ID_RST;
			cfg_host_magic <= HOST_MAGIC_RST;
			cfg_slave_magic <= SLAVE_MAGIC_RST;
			cfg_target <= VERIFY_TARGET_RST;
			cfg_response_tmo <= RESPONSE_TMO_RST;
			cfg_verify_tmo <= VERIFY_TMO_RST;
			cfg_silent_done <= SILENT_DONE_RST;
			ph = PH_IDLE;
			en_seen = 1'b0;
			wait_from_ms = '0;
			last_ping_at = '0;
			pings = '0;
			goal_met = 1'b0;
			granted_addr = '0;
			link_addr = DEFAULT_ADDRESS_RST;
			pending_outcomes.delete();
			fail_count = 0;
			beats_seen = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Register writes only happen while nothing is in flight.
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					REG_DEFAULT_ADDRESS: cfg_default_addr <= cfg_data;
					REG_DEVICE_ID:       cfg_device_id <= cfg_data[WORD_W-1:0];
					REG_HOST_MAGIC:      cfg_host_magic <= cfg_data[WORD_W-1:0];
					REG_SLAVE_MAGIC:     cfg_slave_magic <= cfg_data[WORD_W-1:0];
					REG_VERIFY_TARGET:   cfg_target <= cfg_data[COUNT_W-1:0];
					REG_RESPONSE_TMO:    cfg_response_tmo <= cfg_data[TMO_W-1:0];
					REG_VERIFY_TMO:      cfg_verify_tmo <= cfg_data[TMO_W-1:0];
					REG_SILENT_DONE:     cfg_silent_done <= cfg_data[TMO_W-1:0];
					default: ;
				endcase
			end

			// Compare each result beat against the oldest prediction.
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result beat arrived with no poll waiting for it");
				end else begin
					want = pending_outcomes.pop_front();
					check_field("send_valid", result.send_valid, want.send_valid);
					check_field("send_kind", result.send_kind, want.send_kind);
					check_field("send_word", result.send_word, want.send_word);
					check_field("send_address", result.send_address, want.send_address);
					check_field("link_address", result.link_address, want.link_address);
					check_field("rx_flush", result.rx_flush, want.rx_flush);
					check_field("phase", result.phase, want.phase);
					check_field("verify_count", result.verify_count, want.verify_count);
					check_field("finish", result.finish, want.finish);
				end
				beats_seen++;
			end

			if (poll.valid === 1'b1 && poll.ready === 1'b1) begin
				predict_poll(fresh);
				pending_outcomes.push_back(fresh);
			end

			outstanding <= pending_outcomes.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// Drives polls that walk the pairing exchange (requests, responses, pings,
// silence and timeouts) under several register settings, with random gaps
// on both channels, and reports the verdict from the checker's counts.
module tb;
	import rpsf_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0]  default_address;
		logic [WORD_W-1:0]  device_id;
		logic [WORD_W-1:0]  host_magic;
		logic [WORD_W-1:0]  slave_magic;
		logic [COUNT_W-1:0] verify_target;
		logic [TMO_W-1:0]   response_tmo;
		logic [TMO_W-1:0]   verify_tmo;
		logic [TMO_W-1:0]   silent_done;
	} pairing_cfg_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	int unsigned          mismatches;
	int unsigned          outstanding;

	pairing_cfg_t         link_cfg;
	logic [TIME_W-1:0]    clock_ms;
	bit                   sender_eager;
	bit                   hold_req;
	int unsigned          offers;

	rpsf_poll_if   poll_ch ();
	rpsf_result_if result_ch ();

	radio_pairing_slave_fsm_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.poll      (poll_ch),
		.result    (result_ch)
	);

	rpsf_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.poll        (poll_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result receiver: random stalls per beat, eager stretches, and one long
	// hold-off on request.
	initial begin
		int  stall;
		int  beat_count;
		bit  eager;
		result_ch.ready = 1'b0;
		beat_count = 0;
		eager = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (beat_count % 50 == 0)
				eager = ($urandom_range(0, 3) == 0);
			stall = eager ? 0 : $urandom_range(0, 12);
			if (hold_req) begin
				stall = 80;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			beat_count++;
		end
	end

	// Offers one poll beat after a random gap and waits until it is taken.
	task automatic offer_poll(input logic en, input logic [TIME_W-1:0] now,
			input logic rv, input logic [LEN_W-1:0] len, input logic [CMD_W-1:0] cmd,
			input logic [WORD_W-1:0] magic, input logic [ADDR_W-1:0] addr);
		int gap;
		if (offers % 64 == 0)
			sender_eager = ($urandom_range(0, 3) == 0);
		offers++;
		gap = sender_eager ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			poll_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.enable <= en;
		poll_ch.now_ms <= now;
		poll_ch.rx_valid <= rv;
		poll_ch.rx_length <= len;
		poll_ch.rx_command <= cmd;
		poll_ch.rx_magic <= magic;
		poll_ch.rx_granted_address <= addr;
		do @(posedge clk); while (poll_ch.ready !== 1'b1);
	endtask

	// Stops offering and waits until every poll has its result back.
	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		poll_ch.valid <= 1'b0;
		do begin
			@(negedge clk);
			guard++;
		end while (outstanding != 0 && guard < 5000);
	endtask

	// Writes all eight registers while the block is idle.
	task automatic program_link(input pairing_cfg_t c);
		settle();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEFAULT_ADDRESS;
		cfg_data <= c.default_address;
		@(negedge clk);
		cfg_index <= REG_DEVICE_ID;
		cfg_data <= ADDR_W'(c.device_id);
		@(negedge clk);
		cfg_index <= REG_HOST_MAGIC;
		cfg_data <= ADDR_W'(c.host_magic);
		@(negedge clk);
		cfg_index <= REG_SLAVE_MAGIC;
		cfg_data <= ADDR_W'(c.slave_magic);
		@(negedge clk);
		cfg_index <= REG_VERIFY_TARGET;
		cfg_data <= ADDR_W'(c.verify_target);
		@(negedge clk);
		cfg_index <= REG_RESPONSE_TMO;
		cfg_data <= ADDR_W'(c.response_tmo);
		@(negedge clk);
		cfg_index <= REG_VERIFY_TMO;
		cfg_data <= ADDR_W'(c.verify_tmo);
		@(negedge clk);
		cfg_index <= REG_SILENT_DONE;
		cfg_data <= ADDR_W'(c.silent_done);
		@(negedge clk);
		cfg_we <= 1'b0;
		link_cfg = c;
	endtask

	// Random pairing sessions: enable high for a stretch of polls carrying a
	// mix of responses, valid pings, near misses and noise, then a few polls
	// with enable low. Time advances mostly in small steps against the
	// timeouts, sometimes further, and now and then by a wrapping jump.
	task automatic drive_phase(input int polls, input int ping_pct, input int resp_pct,
			input int step_max, input int sess_min, input int sess_max,
			input int big_pct, input bit pressure);
		int                 sent;
		int                 sess_len;
		int                 k;
		int                 pick;
		logic               en;
		logic               rv;
		logic [LEN_W-1:0]   len;
		logic [CMD_W-1:0]   cmd;
		logic [WORD_W-1:0]  magic;
		logic [ADDR_W-1:0]  addr;
		sent = 0;
		while (sent < polls) begin
			sess_len = $urandom_range(sess_min, sess_max) + $urandom_range(1, 3);
			for (k = 0; k < sess_len && sent < polls; k++) begin
				en = (k < sess_len - 3) || ($urandom_range(0, 1) == 0 && k < sess_len - 1);
				rv = 1'b1;
				len = LEN_W'($urandom_range(0, 32));
				cmd = CMD_W'($urandom);
				magic = $urandom;
				addr = ADDR_W'({$urandom, $urandom});
				pick = $urandom_range(0, 99);
				if (pick < resp_pct) begin
					len = RESPONSE_LENGTH;
					cmd = CMD_RESPONSE_CODE;
				end else if (pick < resp_pct + ping_pct) begin
					len = VERIFY_LENGTH;
					cmd = CMD_PING_CODE;
					magic = link_cfg.host_magic;
				end else if (pick < resp_pct + ping_pct + 15) begin
					// Near misses: one thing off from a packet that would count.
					len = VERIFY_LENGTH;
					cmd = CMD_PING_CODE;
					magic = link_cfg.host_magic;
					case ($urandom_range(0, 4))
						0: rv = 1'b0;
						1: begin
							len = LEN_W'($urandom_range(0, 32));
							if (len == VERIFY_LENGTH)
								len = RESPONSE_LENGTH;
						end
						2: cmd = CMD_PONG_CODE;
						3: magic = link_cfg.host_magic ^ (32'd1 << $urandom_range(0, 31));
						default: begin
							len = RESPONSE_LENGTH;
							cmd = ($urandom_range(0, 1) == 0) ? CMD_REQUEST_CODE : CMD_PING_CODE;
						end
					endcase
				end else begin
					rv = 1'($urandom_range(0, 1));
				end

				pick = $urandom_range(0, 99);
				if (pick < big_pct)
					clock_ms += $urandom;
				else if (pick < big_pct + 15)
					clock_ms += $urandom_range(0, 3 * step_max);
				else
					clock_ms += $urandom_range(0, step_max);

				offer_poll(en, clock_ms, rv, len, cmd, magic, addr);
				sent++;

				if (pressure && sent == polls / 3)
					settle();
				if (pressure && sent == polls / 2) begin
					hold_req = 1'b1;
					sender_eager = 1'b1;
				end
			end
		end
	endtask

	initial begin
		pairing_cfg_t c;
		int           top_tmo;
		int           n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		poll_ch.valid = 1'b0;
		poll_ch.enable = 1'b0;
		poll_ch.now_ms = '0;
		poll_ch.rx_valid = 1'b0;
		poll_ch.rx_length = '0;
		poll_ch.rx_command = '0;
		poll_ch.rx_magic = '0;
		poll_ch.rx_granted_address = '0;
		sender_eager = 1'b0;
		hold_req = 1'b0;
		offers = 0;
		link_cfg.default_address = DEFAULT_ADDRESS_RST;
		link_cfg.device_id = DEVICE_ID_RST;
		link_cfg.host_magic = HOST_MAGIC_RST;
		link_cfg.slave_magic = SLAVE_MAGIC_RST;
		link_cfg.verify_target = VERIFY_TARGET_RST;
		link_cfg.response_tmo = RESPONSE_TMO_RST;
		link_cfg.verify_tmo = VERIFY_TMO_RST;
		link_cfg.silent_done = SILENT_DONE_RST;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed walk through the exchange with the reset settings, with
		// the time stamp wrapping through zero during the first response wait.
		clock_ms = 32'hFFFF_FFC0;
		offer_poll(1'b0, 32'hFFFF_FFFF, 1'b1, 6'd32, 8'hFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		offer_poll(1'b1, clock_ms, 1'b1, VERIFY_LENGTH, CMD_PING_CODE, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b1, RESPONSE_LENGTH, CMD_RESPONSE_CODE, 32'd0, 40'd1);
		clock_ms += 50;
		offer_poll(1'b1, clock_ms, 1'b1, RESPONSE_LENGTH, CMD_REQUEST_CODE, 32'd0, 40'd2);
		// Exactly at the timeout: the compare is strict, so no resend yet.
		clock_ms += 50;
		offer_poll(1'b1, clock_ms, 1'b1, 6'd5, CMD_RESPONSE_CODE, 32'd0, 40'd3);
		clock_ms += 1;
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b1, RESPONSE_LENGTH, CMD_RESPONSE_CODE, 32'h1234_5678,
			40'hFF_FFFF_FFFF);
		clock_ms += 10;
		offer_poll(1'b1, clock_ms, 1'b1, VERIFY_LENGTH, CMD_PING_CODE, 32'hFFFF_FFFF, 40'd0);
		clock_ms += 10;
		offer_poll(1'b1, clock_ms, 1'b1, 6'd7, CMD_PING_CODE, 32'd0, 40'd0);
		for (n = 0; n < 5; n++) begin
			clock_ms += 10;
			offer_poll(1'b1, clock_ms, 1'b1, VERIFY_LENGTH, CMD_PING_CODE, 32'd0,
				ADDR_W'({$urandom, $urandom}));
		end
		// Silence equal to the limit keeps verifying; one more millisecond ends it.
		clock_ms += 3000;
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		clock_ms += 1;
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b1, VERIFY_LENGTH, CMD_PING_CODE, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b0, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		clock_ms += 101;
		offer_poll(1'b1, clock_ms, 1'b0, RESPONSE_LENGTH, CMD_RESPONSE_CODE, 32'd0, 40'd5);
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b1, clock_ms, 1'b1, RESPONSE_LENGTH, CMD_RESPONSE_CODE, 32'd0, 40'd0);
		// Verify timeout before the goal falls back to requesting.
		clock_ms += 5001;
		offer_poll(1'b1, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);
		offer_poll(1'b0, clock_ms, 1'b0, 6'd0, 8'd0, 32'd0, 40'd0);

		drive_phase(250, 45, 15, 1200, 20, 60, 3, 1'b0);

		// Smallest legal settings.
		c.default_address = '0;
		c.device_id = '0;
		c.host_magic = 32'hFFFF_FFFF;
		c.slave_magic = '0;
		c.verify_target = 8'd1;
		c.response_tmo = 16'd1;
		c.verify_tmo = 16'd1;
		c.silent_done = 16'd1;
		program_link(c);
		drive_phase(250, 45, 15, 3, 10, 40, 2, 1'b1);

		// Zero target and zero timeouts.
		c.default_address = 40'hA5_5A5A_A5A5;
		c.device_id = $urandom;
		c.host_magic = $urandom;
		c.slave_magic = $urandom;
		c.verify_target = 8'd0;
		c.response_tmo = 16'd0;
		c.verify_tmo = 16'd0;
		c.silent_done = 16'd0;
		program_link(c);
		drive_phase(200, 45, 15, 2, 10, 40, 2, 1'b0);

		// Largest settings: one long session that drives the ping count into
		// saturation.
		c.default_address = 40'hFF_FFFF_FFFF;
		c.device_id = 32'hFFFF_FFFF;
		c.host_magic = 32'h8000_0001;
		c.slave_magic = 32'hFFFF_FFFF;
		c.verify_target = 8'd255;
		c.response_tmo = 16'hFFFF;
		c.verify_tmo = 16'hFFFF;
		c.silent_done = 16'hFFFF;
		program_link(c);
		drive_phase(600, 85, 10, 300, 600, 600, 0, 1'b0);

		// Random settings with short timeouts so every path recurs often.
		for (n = 0; n < 3; n++) begin
			c.default_address = ADDR_W'({$urandom, $urandom});
			c.device_id = $urandom;
			c.host_magic = $urandom;
			c.slave_magic = $urandom;
			c.verify_target = COUNT_W'($urandom_range(1, 8));
			c.response_tmo = TMO_W'($urandom_range(1, 400));
			c.verify_tmo = TMO_W'($urandom_range(1, 400));
			c.silent_done = TMO_W'($urandom_range(1, 400));
			top_tmo = c.response_tmo;
			if (c.verify_tmo > top_tmo)
				top_tmo = c.verify_tmo;
			if (c.silent_done > top_tmo)
				top_tmo = c.silent_done;
			program_link(c);
			drive_phase(200, 45, 15, top_tmo / 3 + 1, 20, 60, 3, n == 1);
		end

		settle();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
